[src/utf8_stream_decoder_assert.svh]
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// clocked check, held off while reset is low
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define UTF8D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTF8D_ASSERT(lbl, prop, msg)
`define UTF8D_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/utf8d_pkg.sv]
// shared types and constants of the utf8 stream decoder
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned PEND_W    = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [31:0]      MAX_STRING_BYTES_DEF = 32'd65536;
  localparam logic [CNT_W-1:0] CNT_FIELD_MAX        = 17'h1FFFF;
  localparam logic [CP_W-1:0]  REPLACEMENT_CP       = 21'h00FFFD;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0]  codepoint;
    status_t          status;
    logic             string_valid;
    logic [CNT_W-1:0] char_num;
    logic             end_of_string;
  } res_t;

endpackage

[src/utf8_stream_decoder.sv]
// path: input register, then the decode step, then the result register
// throughput: one byte per cycle while results are taken, set by the single
//   decode step between the input register and the result register
// mid-character bytes give no result but still pass the decode step
// reset: synchronous active-low rst_n clears both stages and the decode state
`timescale 1ns / 1ps

module utf8_stream_decoder #(
  parameter logic [31:0] MAX_STRING_BYTES = utf8d_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // byte request side
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [utf8d_pkg::IN_TDATA_W-1:0]    in_tdata,  // [7:0] byte_in
  input  logic                                in_tlast,  // last_byte
  // result side
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [20:0] codepoint, [21] string_valid, [38:22] char_num, [39] zero
  output logic [utf8d_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [1:0]                          out_tuser, // [1:0] status
  output logic                                out_tlast  // end_of_string
);

  utf8d_pkg::item_t in_item;
  utf8d_pkg::item_t item;
  utf8d_pkg::res_t  res;
  utf8d_pkg::res_t  out_res;
  logic             item_valid;
  logic             take;
  logic             res_valid;

  // pack the incoming request
  assign in_item.data_byte = in_tdata;
  assign in_item.last      = in_tlast;

  // input register: holds one byte while the decode step waits
  utf8d_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // decode step and running string state
  utf8d_core #(
    .MAX_STRING_BYTES (MAX_STRING_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register, parts the two stream sides
  utf8d_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // unpack the result onto the stream fields
  assign out_tdata = {1'b0, out_res.char_num, out_res.string_valid, out_res.codepoint};
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.end_of_string;

endmodule

[src/utf8d_in_reg.sv]
// input register stage holding one byte request
`timescale 1ns / 1ps

module utf8d_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  utf8d_pkg::item_t in_item,
  output logic             item_valid,
  output utf8d_pkg::item_t item,
  input  logic             take
);

  logic             valid_r, valid_nxt;
  utf8d_pkg::item_t item_r;
  logic             fire;

  assign in_ready   = !valid_r || take;
  assign fire       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item_r <= in_item;
    end
  end

endmodule

[src/utf8d_core.sv]
// decode state and single-step byte decode
`timescale 1ns / 1ps
`include "utf8_stream_decoder_assert.svh"

module utf8d_core #(
  parameter logic [31:0] MAX_STRING_BYTES = utf8d_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  utf8d_pkg::item_t item,
  input  logic             take,
  output logic             res_valid,
  output utf8d_pkg::res_t  res
);

  localparam int unsigned CP_W  = utf8d_pkg::CP_W;
  localparam int unsigned CNT_W = utf8d_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CntCap =
    (MAX_STRING_BYTES < 32'(utf8d_pkg::CNT_FIELD_MAX)) ?
    MAX_STRING_BYTES[CNT_W-1:0] : utf8d_pkg::CNT_FIELD_MAX;

  logic [utf8d_pkg::PEND_W-1:0] pend_r, pend_nxt;
  logic [CP_W-1:0]              accum_r, accum_nxt;
  logic                         cerr_r, cerr_nxt;
  logic                         aval_r, aval_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;

  logic                         step;
  logic                         emit;
  logic                         bad_cont;
  logic [CP_W-1:0]              shifted;
  logic [utf8d_pkg::PEND_W-1:0] pend_dec;
  logic [CNT_W-1:0]             cnt_bump;
  logic [7:0]                   b;

  assign step     = item_valid && take;
  assign b        = item.data_byte;
  assign bad_cont = (b[7:6] != 2'b10);
  assign shifted  = {accum_r[CP_W-7:0], b[5:0]};
  assign pend_dec = pend_r - 2'd1;
  assign cnt_bump = (cnt_r < CntCap) ? cnt_r + 17'd1 : cnt_r;

  always_comb begin
    pend_nxt          = pend_r;
    accum_nxt         = accum_r;
    cerr_nxt          = cerr_r;
    aval_nxt          = aval_r;
    cnt_nxt           = cnt_r;
    emit              = 1'b0;
    res.codepoint     = '0;
    res.status        = utf8d_pkg::ST_OK;
    res.string_valid  = 1'b0;
    res.char_num      = '0;
    res.end_of_string = item.last;

    if (pend_r == '0) begin
      cerr_nxt = 1'b0;
      unique case (b) inside
        8'b0???????: begin
          res.codepoint = {13'd0, b};
          emit          = 1'b1;
        end
        8'b110?????: begin
          accum_nxt = {16'd0, b[4:0]};
          pend_nxt  = 2'd1;
        end
        8'b1110????: begin
          accum_nxt = {17'd0, b[3:0]};
          pend_nxt  = 2'd2;
        end
        8'b11110???: begin
          accum_nxt = {18'd0, b[2:0]};
          pend_nxt  = 2'd3;
        end
        default: begin
          res.codepoint = utf8d_pkg::REPLACEMENT_CP;
          res.status    = utf8d_pkg::ST_BAD_LEAD;
          aval_nxt      = 1'b0;
          emit          = 1'b1;
        end
      endcase
    end else begin
      // continuation byte, consumed even without the 10 prefix
      cerr_nxt  = cerr_r || bad_cont;
      aval_nxt  = aval_r && !bad_cont;
      accum_nxt = shifted;
      pend_nxt  = pend_dec;
      if (pend_dec == '0) begin
        res.codepoint = shifted;
        res.status    = cerr_nxt ? utf8d_pkg::ST_BAD_CONT : utf8d_pkg::ST_OK;
        emit          = 1'b1;
        accum_nxt     = '0;
        cerr_nxt      = 1'b0;
      end
    end

    // string ends mid-character
    if (!emit && item.last) begin
      res.codepoint = '0;
      res.status    = utf8d_pkg::ST_TRUNC;
      aval_nxt      = 1'b0;
      emit          = 1'b1;
    end

    if (emit) begin
      cnt_nxt = cnt_bump;
    end
    res.string_valid = aval_nxt;
    res.char_num     = cnt_nxt;

    if (item.last) begin
      pend_nxt  = '0;
      accum_nxt = '0;
      cerr_nxt  = 1'b0;
      aval_nxt  = 1'b1;
      cnt_nxt   = '0;
    end
  end

  assign res_valid = step && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      accum_r <= '0;
      cerr_r  <= 1'b0;
      aval_r  <= 1'b1;
      cnt_r   <= '0;
    end else if (step) begin
      pend_r  <= pend_nxt;
      accum_r <= accum_nxt;
      cerr_r  <= cerr_nxt;
      aval_r  <= aval_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `UTF8D_ASSERT(a_last_clears, (step && item.last) |=> (pend_r == '0 && cnt_r == '0 && aval_r && !cerr_r), "state not cleared after last byte")
  `UTF8D_ASSERT(a_last_emits, (step && item.last) |-> res_valid, "last byte gave no result")
  `UTF8D_ASSERT(a_trunc_form, (res_valid && res.status == utf8d_pkg::ST_TRUNC) |-> (res.codepoint == '0 && !res.string_valid), "truncated result malformed")
  `UTF8D_ASSERT(a_bad_lead_cp, (res_valid && res.status == utf8d_pkg::ST_BAD_LEAD) |-> (res.codepoint == utf8d_pkg::REPLACEMENT_CP && !res.string_valid), "bad lead result malformed")
  `UTF8D_ASSERT_ALWAYS(a_cnt_cap, !rst_n || cnt_r <= CntCap, "character counter above cap")

endmodule

[src/utf8d_out_reg.sv]
// result register towards the output stream
`timescale 1ns / 1ps

module utf8d_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  input  utf8d_pkg::res_t res,
  output logic            take,
  output logic            out_valid,
  input  logic            out_ready,
  output utf8d_pkg::res_t out_res
);

  logic            valid_r, valid_nxt;
  utf8d_pkg::res_t res_r;

  // stage may move when the register is empty or drains this cycle
  assign take      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

[tb/tb.sv]
// testbench for the utf8 stream decoder: table of directed bytes, random strings and a long string
`timescale 1ns / 1ps

module tb;
  import utf8d_pkg::*;

  localparam int RANDOM_BYTES = 480;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 2_000_000;
  // the character count stops at the smaller of the string size and the field range
  localparam logic [CNT_W-1:0] COUNT_CAP =
    (MAX_STRING_BYTES_DEF < {15'd0, CNT_FIELD_MAX}) ? MAX_STRING_BYTES_DEF[CNT_W-1:0]
                                                     : CNT_FIELD_MAX;
  localparam int LONG_CHARS = 40;

  // one byte request, with the decoded character typed in where it is obvious
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    res_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  // decoder state as the byte stream leaves it
  logic [PEND_W-1:0] pend_bytes = '0;
  logic [CP_W-1:0]   cp_accum = '0;
  logic              cont_bad = 1'b0;
  logic              str_ok = 1'b1;
  logic [CNT_W-1:0]  char_total = '0;

  res_t due_chars[$];
  stim_row_t dir_rows[$];
  int sent_bytes = 0;
  int checked = 0;
  int strings_closed = 0;
  int mismatches = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int hold_asks = 0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  utf8_stream_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // advances the decoder state by one byte, returns 1 when a character comes out
  function automatic bit decode_byte(input logic [7:0] b, input logic last, output res_t r);
    bit hit;
    logic [CP_W-1:0] cp;
    status_t st;
    hit = 1'b0;
    cp = '0;
    st = ST_OK;
    if (pend_bytes == 0) begin
      if (!b[7]) begin
        cp = {13'd0, b};
        hit = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        cp_accum = {16'd0, b[4:0]};
        pend_bytes = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_accum = {17'd0, b[3:0]};
        pend_bytes = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_accum = {18'd0, b[2:0]};
        pend_bytes = 2'd3;
      end else begin
        cp = REPLACEMENT_CP;
        st = ST_BAD_LEAD;
        str_ok = 1'b0;
        hit = 1'b1;
      end
      cont_bad = 1'b0;
    end else begin
      // a byte without the 10 prefix is still taken as a continuation
      if (b[7:6] != 2'b10) begin
        cont_bad = 1'b1;
        str_ok = 1'b0;
      end
      cp_accum = {cp_accum[CP_W-7:0], b[5:0]};
      pend_bytes = pend_bytes - 2'd1;
      if (pend_bytes == 0) begin
        cp = cp_accum;
        st = cont_bad ? ST_BAD_CONT : ST_OK;
        hit = 1'b1;
        cp_accum = '0;
        cont_bad = 1'b0;
      end
    end
    // string closed partway through a character
    if (!hit && last) begin
      cp = '0;
      st = ST_TRUNC;
      str_ok = 1'b0;
      hit = 1'b1;
    end
    if (hit && char_total < COUNT_CAP)
      char_total = char_total + 1'b1;
    r.codepoint = cp;
    r.status = st;
    r.string_valid = str_ok;
    r.char_num = char_total;
    r.end_of_string = last;
    if (last) begin
      pend_bytes = '0;
      cp_accum = '0;
      cont_bad = 1'b0;
      str_ok = 1'b1;
      char_total = '0;
    end
    return hit;
  endfunction

  function automatic stim_row_t plain(input logic [7:0] b, input logic last);
    stim_row_t r;
    r = '0;
    r.b = b;
    r.last = last;
    return r;
  endfunction

  function automatic stim_row_t known(input logic [7:0] b, input logic last,
                                      input logic [CP_W-1:0] cp, input status_t st,
                                      input logic sv, input logic [CNT_W-1:0] cnt);
    stim_row_t r;
    r.b = b;
    r.last = last;
    r.typed = 1'b1;
    r.want.codepoint = cp;
    r.want.status = st;
    r.want.string_valid = sv;
    r.want.char_num = cnt;
    r.want.end_of_string = last;
    return r;
  endfunction

  // offers one byte request, holds it until taken and books the character it closes
  task automatic send_row(input stim_row_t row);
    res_t got;
    bit hit;
    while (!no_gaps && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= row.b;
    in_tlast <= row.last;
    do @(posedge clk); while (!in_tready);
    hit = decode_byte(row.b, row.last, got);
    if (row.typed) begin
      got = row.want;
      hit = 1'b1;
    end
    if (hit)
      due_chars.push_back(got);
    sent_bytes++;
  endtask

  // one random character: mostly well formed, sometimes broken, cut short or noise
  task automatic send_char(input bit close_str);
    logic [7:0] seq [4];
    int len, kind, k, keep, pick;
    kind = $urandom_range(0, 99);
    len = $urandom_range(1, 4);
    case (len)
      1: seq[0] = {1'b0, 7'($urandom)};
      2: seq[0] = {3'b110, 5'($urandom)};
      3: seq[0] = {4'b1110, 4'($urandom)};
      default: seq[0] = {5'b11110, 3'($urandom)};
    endcase
    for (k = 1; k < 4; k++)
      seq[k] = {2'b10, 6'($urandom)};
    keep = len;
    if (kind < 6) begin
      // stray continuation or a byte from f8 up as lead
      seq[0] = $urandom_range(0, 1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
      keep = 1;
    end else if (kind < 12 && len > 1) begin
      k = $urandom_range(1, len - 1);
      pick = $urandom_range(0, 2);
      seq[k][7:6] = (pick == 2) ? 2'b11 : 2'(pick);
    end else if (kind < 16) begin
      seq[0] = 8'($urandom);
      keep = 1;
    end else if (kind < 22 && close_str && len > 1) begin
      keep = $urandom_range(1, len - 1);
    end
    for (k = 0; k < keep; k++)
      send_row(plain(seq[k], close_str && k == keep - 1));
  endtask

  // receiver: random stalls, plus a long hold-off whenever the sender asks for one
  initial begin : result_drain
    int holds_done;
    int hold_cnt;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asks) begin
        holds_done++;
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++)
          @(posedge clk);
      end
      out_tready <= no_gaps || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tdata %h tuser %0d tlast %b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = due_chars.pop_front();
        checked++;
        status_seen[out_tuser]++;
        if (out_tlast)
          strings_closed++;
        if (out_tdata[20:0] != want.codepoint || out_tuser != want.status ||
            out_tdata[21] != want.string_valid || out_tdata[38:22] != want.char_num ||
            out_tlast != want.end_of_string || out_tdata[39] != 1'b0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want cp %h st %0d sv %b cnt %0d eos %b",
                     want.codepoint, want.status, want.string_valid, want.char_num,
                     want.end_of_string);
            $display("          got cp %h st %0d sv %b cnt %0d eos %b pad %b",
                     out_tdata[20:0], out_tuser, out_tdata[21], out_tdata[38:22],
                     out_tlast, out_tdata[39]);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
      @(posedge clk);
    $display("timeout after %0d cycles, %0d characters still due", cycle_count,
             due_chars.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int i, c, nchars, str_idx, dir_bytes;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ascii extremes, one character of each length, the largest code point 10ffff
    dir_rows.push_back(known(8'h00, 1'b0, 21'h0, ST_OK, 1'b1, 17'd1));
    dir_rows.push_back(known(8'h7F, 1'b0, 21'h7F, ST_OK, 1'b1, 17'd2));
    dir_rows.push_back(plain(8'hC3, 1'b0));
    dir_rows.push_back(plain(8'hA9, 1'b0));
    dir_rows.push_back(plain(8'hE2, 1'b0));
    dir_rows.push_back(plain(8'h82, 1'b0));
    dir_rows.push_back(plain(8'hAC, 1'b0));
    dir_rows.push_back(plain(8'hF4, 1'b0));
    dir_rows.push_back(plain(8'h8F, 1'b0));
    dir_rows.push_back(plain(8'hBF, 1'b0));
    dir_rows.push_back(plain(8'hBF, 1'b0));
    // invalid lead, bad continuation, then the string cut inside a character
    dir_rows.push_back(known(8'hFF, 1'b0, REPLACEMENT_CP, ST_BAD_LEAD, 1'b0, 17'd6));
    dir_rows.push_back(plain(8'hC2, 1'b0));
    dir_rows.push_back(plain(8'h41, 1'b0));
    dir_rows.push_back(known(8'hE0, 1'b1, 21'h0, ST_TRUNC, 1'b0, 17'd8));
    dir_rows.push_back(plain(8'hF7, 1'b0));
    dir_rows.push_back(plain(8'hBF, 1'b0));
    dir_rows.push_back(plain(8'hBF, 1'b0));
    dir_rows.push_back(plain(8'hBF, 1'b0));
    dir_rows.push_back(known(8'h80, 1'b0, REPLACEMENT_CP, ST_BAD_LEAD, 1'b0, 17'd2));
    dir_rows.push_back(known(8'hF8, 1'b0, REPLACEMENT_CP, ST_BAD_LEAD, 1'b0, 17'd3));
    dir_rows.push_back(known(8'h41, 1'b1, 21'h41, ST_OK, 1'b0, 17'd4));
    // one-byte string, then truncation winning over a bad continuation
    dir_rows.push_back(known(8'h00, 1'b1, 21'h0, ST_OK, 1'b1, 17'd1));
    dir_rows.push_back(plain(8'hE1, 1'b0));
    dir_rows.push_back(known(8'h00, 1'b1, 21'h0, ST_TRUNC, 1'b0, 17'd1));
    for (i = 0; i < dir_rows.size(); i++)
      send_row(dir_rows[i]);
    dir_bytes = sent_bytes;

    // random strings; a long receiver hold-off, a gap-free stretch and a full drain on the way
    str_idx = 0;
    while (sent_bytes < dir_bytes + RANDOM_BYTES) begin
      if (str_idx == 4)
        hold_asks <= hold_asks + 1;
      no_gaps <= (str_idx >= 10 && str_idx < 18);
      if (str_idx == 22) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (due_chars.size() != 0) @(posedge clk);
      end
      nchars = $urandom_range(1, 12);
      for (c = 0; c < nchars; c++)
        send_char(c == nchars - 1);
      str_idx++;
    end
    no_gaps <= 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    // one last ascii string after a full drain
    while (due_chars.size() != 0) @(posedge clk);
    for (i = 0; i < LONG_CHARS; i++)
      send_row(plain({1'b0, 7'($urandom)}, i == LONG_CHARS - 1));

    in_tvalid <= 1'b0;
    while (due_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d byte requests in %0d strings, %0d characters checked",
             sent_bytes, strings_closed, checked);
    $display("ok %0d, bad lead %0d, bad continuation %0d, truncated %0d, count cap %0d",
             status_seen[ST_OK], status_seen[ST_BAD_LEAD], status_seen[ST_BAD_CONT],
             status_seen[ST_TRUNC], COUNT_CAP);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/utf8d_pkg.sv
src/utf8d_in_reg.sv
src/utf8d_core.sv
src/utf8d_out_reg.sv
src/utf8_stream_decoder.sv
tb/tb.sv
